FILE: sv/point_translate_scale_rotate_core_assert.svh
// assertion macros for the vertex transform core
// they expect clk and arst_n in the scope where they are used
`ifndef POINT_TRANSLATE_SCALE_ROTATE_CORE_ASSERT_SVH
`define POINT_TRANSLATE_SCALE_ROTATE_CORE_ASSERT_SVH

// same-cycle implication
`define PSTR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pstr check failed");

// next-cycle implication
`define PSTR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pstr check failed");

`endif

FILE: sv/pstr_pkg.sv
`timescale 1ns / 1ps
package pstr_pkg;

	localparam int TRIG_FRAC_BITS = 15;
	localparam int TRIG_MAG_W     = TRIG_FRAC_BITS + 1;
	localparam int COEF_W         = TRIG_MAG_W + 1;
	localparam int OFFS_W         = 16;
	localparam int SCALE_W        = 8;
	localparam int ANGLE_W        = 9;
	localparam int MODE_W         = 2;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int REM_W          = 7;
	localparam int FULL_TURN      = 360;
	localparam int HALF_TURN      = 180;
	localparam int QUARTER_TURN   = 90;
	localparam int THREE_QUARTERS = 270;

	typedef enum logic [MODE_W-1:0] {
		MODE_TRANSLATE = 2'd0,
		MODE_SCALE     = 2'd1,
		MODE_ROTATE    = 2'd2,
		MODE_PASS      = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE    = 3'd5;

	// side info that travels with each vertex
	typedef struct packed {
		logic last;
		logic rot;
	} ctl_t;

	// round(sin(r deg) * 2^15), r = 0..90
	localparam logic [TRIG_MAG_W-1:0] SIN_LUT [0:90] = '{
		16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
		16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
		16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
		16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
		16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
		16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
		16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
		16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
		16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
		16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
		16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
		16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
		16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
		16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
		16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
		16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
		16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
		16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
		16'd32768
	};

endpackage

FILE: sv/pstr_operand.sv
`timescale 1ns / 1ps
// stage 1: angle reduction, trig lookup and per-mode operand select
module pstr_operand import pstr_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int EXT_W       = 17
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [COORD_WIDTH-1:0] x_in,
	input  logic signed [COORD_WIDTH-1:0] y_in,
	input  logic                        last_in,
	input  mode_t                       mode,
	input  logic signed [OFFS_W-1:0]    offset_x,
	input  logic signed [OFFS_W-1:0]    offset_y,
	input  logic signed [SCALE_W-1:0]   scale_x,
	input  logic signed [SCALE_W-1:0]   scale_y,
	input  logic [ANGLE_W-1:0]          angle_deg,
	output logic signed [EXT_W-1:0]     dx_s1,
	output logic signed [EXT_W-1:0]     dy_s1,
	output logic signed [COEF_W-1:0]    cx_s1,
	output logic signed [COEF_W-1:0]    cy_s1,
	output logic signed [COEF_W-1:0]    sn_s1,
	output ctl_t                        ctl_s1
);

	logic [ANGLE_W-1:0]          a_mod;
	logic [1:0]                  quad;
	logic [REM_W-1:0]            rem;
	logic [TRIG_MAG_W-1:0]       mag_lo, mag_hi, sin_mag, cos_mag;
	logic signed [COEF_W-1:0]    sin_c, cos_c;
	logic signed [EXT_W-1:0]     x_e, y_e, ox_e, oy_e;
	logic signed [EXT_W-1:0]     dx, dy;
	logic signed [COEF_W-1:0]    cx, cy, sn;

	// angle into 0..359, then quadrant and remainder
	always_comb begin
		a_mod = (angle_deg >= ANGLE_W'(FULL_TURN)) ? angle_deg - ANGLE_W'(FULL_TURN)
			: angle_deg;
		if (a_mod >= ANGLE_W'(THREE_QUARTERS)) begin
			quad = 2'd3;
			rem  = REM_W'(a_mod - ANGLE_W'(THREE_QUARTERS));
		end else if (a_mod >= ANGLE_W'(HALF_TURN)) begin
			quad = 2'd2;
			rem  = REM_W'(a_mod - ANGLE_W'(HALF_TURN));
		end else if (a_mod >= ANGLE_W'(QUARTER_TURN)) begin
			quad = 2'd1;
			rem  = REM_W'(a_mod - ANGLE_W'(QUARTER_TURN));
		end else begin
			quad = 2'd0;
			rem  = REM_W'(a_mod);
		end
	end

	// quarter-wave symmetry; cos(a) = sin(a + 90)
	always_comb begin
		mag_lo  = SIN_LUT[rem];
		mag_hi  = SIN_LUT[REM_W'(QUARTER_TURN) - rem];
		sin_mag = quad[0] ? mag_hi : mag_lo;
		cos_mag = quad[0] ? mag_lo : mag_hi;
		sin_c   = quad[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
		cos_c   = (quad[1] ^ quad[0]) ? -$signed({1'b0, cos_mag})
			: $signed({1'b0, cos_mag});
	end

	assign x_e  = {{(EXT_W-COORD_WIDTH){x_in[COORD_WIDTH-1]}}, x_in};
	assign y_e  = {{(EXT_W-COORD_WIDTH){y_in[COORD_WIDTH-1]}}, y_in};
	assign ox_e = {{(EXT_W-OFFS_W){offset_x[OFFS_W-1]}}, offset_x};
	assign oy_e = {{(EXT_W-OFFS_W){offset_y[OFFS_W-1]}}, offset_y};

	// all modes map onto dx*cx - dy*sn and dx*sn + dy*cy
	always_comb begin
		dx = x_e;
		dy = y_e;
		cx = COEF_W'(1);
		cy = COEF_W'(1);
		sn = '0;
		case (mode)
			MODE_TRANSLATE: begin
				dx = x_e + ox_e;
				dy = y_e + oy_e;
			end
			MODE_SCALE: begin
				cx = {{(COEF_W-SCALE_W){scale_x[SCALE_W-1]}}, scale_x};
				cy = {{(COEF_W-SCALE_W){scale_y[SCALE_W-1]}}, scale_y};
			end
			MODE_ROTATE: begin
				dx = x_e - ox_e;
				dy = y_e - oy_e;
				cx = cos_c;
				cy = cos_c;
				sn = sin_c;
			end
			default: begin
				dx = x_e;
				dy = y_e;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1      <= dx;
			dy_s1      <= dy;
			cx_s1      <= cx;
			cy_s1      <= cy;
			sn_s1      <= sn;
			ctl_s1.last <= last_in;
			ctl_s1.rot  <= (mode == MODE_ROTATE);
		end
	end

endmodule

FILE: sv/pstr_mult.sv
`timescale 1ns / 1ps
// stage 2: four products; stage 3: combine, add pivot for rotate
module pstr_mult import pstr_pkg::*; #(
	parameter int EXT_W  = 17,
	parameter int PROD_W = 34,
	parameter int SUM_W  = 36
) (
	input  logic                     clk,
	input  logic                     en2,
	input  logic                     en3,
	input  logic signed [EXT_W-1:0]  dx_s1,
	input  logic signed [EXT_W-1:0]  dy_s1,
	input  logic signed [COEF_W-1:0] cx_s1,
	input  logic signed [COEF_W-1:0] cy_s1,
	input  logic signed [COEF_W-1:0] sn_s1,
	input  ctl_t                     ctl_s1,
	input  logic signed [OFFS_W-1:0] offset_x,
	input  logic signed [OFFS_W-1:0] offset_y,
	output logic signed [SUM_W-1:0]  nx_s3,
	output logic signed [SUM_W-1:0]  ny_s3,
	output ctl_t                     ctl_s3
);

	logic signed [PROD_W-1:0] pa_s2, pb_s2, pc_s2, pd_s2;
	ctl_t                     ctl_s2;
	logic signed [SUM_W-1:0]  base_x, base_y;

	always_ff @(posedge clk) begin
		if (en2) begin
			pa_s2  <= PROD_W'(dx_s1) * PROD_W'(cx_s1);
			pb_s2  <= PROD_W'(dy_s1) * PROD_W'(sn_s1);
			pc_s2  <= PROD_W'(dx_s1) * PROD_W'(sn_s1);
			pd_s2  <= PROD_W'(dy_s1) * PROD_W'(cy_s1);
			ctl_s2 <= ctl_s1;
		end
	end

	// pivot scaled into the fraction format of the products
	assign base_x = ctl_s2.rot ? (SUM_W'(offset_x) <<< TRIG_FRAC_BITS) : '0;
	assign base_y = ctl_s2.rot ? (SUM_W'(offset_y) <<< TRIG_FRAC_BITS) : '0;

	always_ff @(posedge clk) begin
		if (en3) begin
			nx_s3  <= base_x + SUM_W'(pa_s2) - SUM_W'(pb_s2);
			ny_s3  <= base_y + SUM_W'(pc_s2) + SUM_W'(pd_s2);
			ctl_s3 <= ctl_s2;
		end
	end

endmodule

FILE: sv/pstr_sat.sv
`timescale 1ns / 1ps
// stage 4: truncate toward zero for rotate, clamp to coordinate range
module pstr_sat import pstr_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int SUM_W       = 36
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SUM_W-1:0]       nx_s3,
	input  logic signed [SUM_W-1:0]       ny_s3,
	input  ctl_t                          ctl_s3,
	output logic signed [COORD_WIDTH-1:0] x_s4,
	output logic signed [COORD_WIDTH-1:0] y_s4,
	output logic                          sat_s4,
	output logic                          last_s4
);

	localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic signed [SUM_W-1:0]       num [2];
	logic [COORD_WIDTH-1:0]        val [2];
	logic [1:0]                    ovf;

	assign num[0] = nx_s3;
	assign num[1] = ny_s3;

	for (genvar i = 0; i < 2; i++) begin : g_lane
		logic signed [SUM_W-1:0]         flr;
		logic                            fix;
		logic signed [SUM_W-1:0]         t;
		logic [SUM_W-COORD_WIDTH:0]      hi;

		always_comb begin
			flr    = num[i] >>> TRIG_FRAC_BITS;
			// floor of a negative value with fraction bits moves up by one
			fix    = num[i][SUM_W-1] & (|num[i][TRIG_FRAC_BITS-1:0]);
			t      = ctl_s3.rot ? flr + SUM_W'(fix) : num[i];
			hi     = t[SUM_W-1:COORD_WIDTH-1];
			ovf[i] = !((&hi) || !(|hi));
			val[i] = ovf[i] ? (t[SUM_W-1] ? C_MIN : C_MAX) : t[COORD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4    <= val[0];
			y_s4    <= val[1];
			sat_s4  <= |ovf;
			last_s4 <= ctl_s3.last;
		end
	end

endmodule

FILE: sv/point_translate_scale_rotate_core.sv
`timescale 1ns / 1ps
// Vertex transform core: each request carries one polygon vertex (x_in, y_in) and a
// last-vertex mark, and yields one result vertex. Mode 0 adds (offset_x, offset_y),
// mode 1 multiplies by (scale_x, scale_y), mode 2 turns the point counter-clockwise
// by angle_deg whole degrees about the pivot (offset_x, offset_y) using Q2.15 sine
// and cosine from a quarter-wave table, truncating toward zero; mode 3 passes the
// vertex through. Any coordinate outside the signed COORD_WIDTH range is clamped
// and raises saturated; angles above 359 wrap modulo 360. The datapath is a
// four-stage pipeline (operand select and table lookup, multipliers, adders,
// truncate and clamp); one vertex is accepted every clock as long as results are
// taken, and a stalled output stalls only the stages that are full. Configuration
// registers are written through cfg_we / cfg_addr / cfg_wdata and must only
// change while no request is in flight. No memory is cleared after reset.
module point_translate_scale_rotate_core import pstr_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_addr,
	input  logic [CFG_DATA_W-1:0]         cfg_wdata,
	// vertex in
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] x_in,
	input  logic signed [COORD_WIDTH-1:0] y_in,
	input  logic                          last_in,
	// vertex out
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] x_out,
	output logic signed [COORD_WIDTH-1:0] y_out,
	output logic                          saturated,
	output logic                          last_out
);

`include "point_translate_scale_rotate_core_assert.svh"

	// widths: difference/sum with offset, product with a trig coefficient,
	// and the combined sum with the pivot added in
	localparam int EXT_W  = ((COORD_WIDTH > OFFS_W) ? COORD_WIDTH : OFFS_W) + 1;
	localparam int PROD_W = EXT_W + COEF_W;
	localparam int SUM_W  = PROD_W + 2;

	localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// configuration registers
	mode_t                     mode_q;
	logic signed [OFFS_W-1:0]  offset_x_q;
	logic signed [OFFS_W-1:0]  offset_y_q;
	logic signed [SCALE_W-1:0] scale_x_q;
	logic signed [SCALE_W-1:0] scale_y_q;
	logic [ANGLE_W-1:0]        angle_deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_TRANSLATE;
			offset_x_q  <= '0;
			offset_y_q  <= '0;
			scale_x_q   <= SCALE_W'(1);
			scale_y_q   <= SCALE_W'(1);
			angle_deg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MODE:     mode_q      <= mode_t'(cfg_wdata[MODE_W-1:0]);
				CFG_OFFSET_X: offset_x_q  <= cfg_wdata[OFFS_W-1:0];
				CFG_OFFSET_Y: offset_y_q  <= cfg_wdata[OFFS_W-1:0];
				CFG_SCALE_X:  scale_x_q   <= cfg_wdata[SCALE_W-1:0];
				CFG_SCALE_Y:  scale_y_q   <= cfg_wdata[SCALE_W-1:0];
				CFG_ANGLE:    angle_deg_q <= cfg_wdata[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline valid bits; a stage loads when it is empty or the next one moves
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	assign en4 = !valid_s4 || out_ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// stage 1: operands
	logic signed [EXT_W-1:0]  dx_s1, dy_s1;
	logic signed [COEF_W-1:0] cx_s1, cy_s1, sn_s1;
	ctl_t                     ctl_s1;

	pstr_operand #(
		.COORD_WIDTH (COORD_WIDTH),
		.EXT_W       (EXT_W)
	) u_operand (
		.clk       (clk),
		.en        (en1),
		.x_in      (x_in),
		.y_in      (y_in),
		.last_in   (last_in),
		.mode      (mode_q),
		.offset_x  (offset_x_q),
		.offset_y  (offset_y_q),
		.scale_x   (scale_x_q),
		.scale_y   (scale_y_q),
		.angle_deg (angle_deg_q),
		.dx_s1     (dx_s1),
		.dy_s1     (dy_s1),
		.cx_s1     (cx_s1),
		.cy_s1     (cy_s1),
		.sn_s1     (sn_s1),
		.ctl_s1    (ctl_s1)
	);

	// stages 2 and 3: products and sums
	logic signed [SUM_W-1:0] nx_s3, ny_s3;
	ctl_t                    ctl_s3;

	pstr_mult #(
		.EXT_W  (EXT_W),
		.PROD_W (PROD_W),
		.SUM_W  (SUM_W)
	) u_mult (
		.clk      (clk),
		.en2      (en2),
		.en3      (en3),
		.dx_s1    (dx_s1),
		.dy_s1    (dy_s1),
		.cx_s1    (cx_s1),
		.cy_s1    (cy_s1),
		.sn_s1    (sn_s1),
		.ctl_s1   (ctl_s1),
		.offset_x (offset_x_q),
		.offset_y (offset_y_q),
		.nx_s3    (nx_s3),
		.ny_s3    (ny_s3),
		.ctl_s3   (ctl_s3)
	);

	// stage 4: truncate, clamp, output register
	pstr_sat #(
		.COORD_WIDTH (COORD_WIDTH),
		.SUM_W       (SUM_W)
	) u_sat (
		.clk     (clk),
		.en      (en4),
		.nx_s3   (nx_s3),
		.ny_s3   (ny_s3),
		.ctl_s3  (ctl_s3),
		.x_s4    (x_out),
		.y_s4    (y_out),
		.sat_s4  (saturated),
		.last_s4 (last_out)
	);

	assign out_valid = valid_s4;

	// back-pressure only reaches the input once every stage holds a request
	`PSTR_ASSERT_IMP(a_stall_full, !in_ready, valid_s1 && valid_s2 && valid_s3 && valid_s4)
	// an accepted request always lands in stage 1
	`PSTR_ASSERT_NXT(a_accept_lands, in_valid && in_ready, valid_s1)
	// a clamp always shows up as an extreme coordinate
	`PSTR_ASSERT_IMP(a_sat_extreme, out_valid && saturated,
		x_out == COORD_MAX || x_out == COORD_MIN || y_out == COORD_MAX || y_out == COORD_MIN)
	// pass-through can never clamp
	`PSTR_ASSERT_IMP(a_pass_nosat, out_valid && mode_q == MODE_PASS, !saturated)

endmodule
